// ===== rtl/core/gps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_pkg
// Types and constants shared by the randomized Prim spanning tree block.
// ----------------------------------------------------------------------------
package gps_pkg;

   localparam int RAND_W      = 31;
   localparam int CFG_W       = 7;
   localparam int CELL_OUT_W  = 12;
   localparam int LEFT_OUT_W  = 15;
   localparam int EPOCH_W     = 8;
   localparam int CSR_IDX_W   = 1;

   localparam int DEF_MAX_ROWS   = 64;
   localparam int DEF_MAX_COLS   = 64;
   localparam int DEF_EDGE_DEPTH = 16384;

   localparam logic [CFG_W-1:0] GRID_ROWS_RESET = CFG_W'(64);
   localparam logic [CFG_W-1:0] GRID_COLS_RESET = CFG_W'(64);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'b1;

   typedef enum logic [1:0] {
      RSP_STARTED  = 2'd0,
      RSP_CARVED   = 2'd1,
      RSP_SKIPPED  = 2'd2,
      RSP_FINISHED = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      NB_UP    = 2'd0,
      NB_DOWN  = 2'd1,
      NB_LEFT  = 2'd2,
      NB_RIGHT = 2'd3
   } nb_dir_type;

   typedef enum logic [1:0] {
      DIV_ROW  = 2'd0,
      DIV_COL  = 2'd1,
      DIV_PICK = 2'd2
   } div_sel_type;

   typedef enum logic {
      ERD_PICK = 1'b0,
      ERD_LAST = 1'b1
   } edge_rd_sel_type;

   typedef enum logic {
      VRD_NB   = 1'b0,
      VRD_CELL = 1'b1
   } vis_rd_sel_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ST_INIT,
      S_ST_WAITCLR,
      S_ST_DIVR,
      S_ST_DIVC,
      S_DR_START,
      S_DR_DIVW,
      S_DR_RD0,
      S_DR_RD1,
      S_DR_WR,
      S_MUL,
      S_DR_VIS,
      S_DR_CHK,
      S_MARK,
      S_NB_ADDR,
      S_NB_CHK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic            req_ready;
      logic            load_in;
      logic            st_init;
      logic            div_start;
      div_sel_type     div_sel;
      logic            take_row;
      logic            take_col;
      logic            pick_load;
      edge_rd_sel_type edge_rd_sel;
      logic            edge_capture;
      logic            edge_write_pick;
      logic            calc_cell;
      vis_rd_sel_type  vis_rd_sel;
      logic            mark;
      nb_dir_type      nb_dir;
      logic            nb_load;
      logic            push_try;
      logic            rsp_load;
      rsp_status_type  rsp_status;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_op;
      logic op;
      logic count_zero;
      logic clr_busy;
      logic div_done;
      logic vis_seen;
      logic rsp_free;
   } stat_type;

endpackage

// ===== rtl/core/gps_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_req_if
// Request channel: start or draw item with two random words.
// ----------------------------------------------------------------------------
interface gps_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [gps_pkg::RAND_W-1:0] rand_first;
   logic [gps_pkg::RAND_W-1:0] rand_second;

   modport source (output valid, op, rand_first, rand_second, input ready);
   modport sink   (input valid, op, rand_first, rand_second, output ready);
endinterface

// ===== rtl/core/gps_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface gps_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [gps_pkg::CELL_OUT_W-1:0] visited_cell;
   logic [gps_pkg::CELL_OUT_W-1:0] parent_cell;
   logic [gps_pkg::LEFT_OUT_W-1:0] edges_left;

   modport source (output valid, status, visited_cell, parent_cell, edges_left,
                   input ready);
   modport sink   (input valid, status, visited_cell, parent_cell, edges_left,
                   output ready);
endinterface

// ===== rtl/core/gps_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface gps_csr_if;
   logic                          valid;
   logic                          ready;
   logic [gps_pkg::CSR_IDX_W-1:0] index;
   logic [gps_pkg::CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/gps_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_div
// Restoring divider, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module gps_div #(
   parameter int DIV_W = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gps_pkg::RAND_W-1:0] dividend,
   input  logic [DIV_W-1:0]           divisor,
   output logic                       done,
   output logic [DIV_W-1:0]           remainder
);
   localparam int CNT_W = $clog2(gps_pkg::RAND_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [DIV_W-1:0]           rem_ff, rem_in;
   logic [gps_pkg::RAND_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]           dvs_ff, dvs_in;
   logic [DIV_W:0]             trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[gps_pkg::RAND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[gps_pkg::RAND_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = DIV_W'(trial);
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(gps_pkg::RAND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/gps_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_dp
// Datapath: registers, visited map with epoch tags, edge list, divider and
// response register.
// ----------------------------------------------------------------------------
module gps_dp #(
   parameter int MAX_ROWS   = gps_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = gps_pkg::DEF_MAX_COLS,
   parameter int EDGE_DEPTH = gps_pkg::DEF_EDGE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   gps_req_if.sink           req_chan,
   gps_rsp_if.source         rsp_chan,
   gps_csr_if.sink           csr_chan,
   input  gps_pkg::cmd_type  cmd,
   output gps_pkg::stat_type stat
);
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CLW   = $clog2(MAX_COLS + 1);
   localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int EAW   = $clog2(EDGE_DEPTH);
   localparam int KW    = $clog2(EDGE_DEPTH + 1);
   localparam int DVW0  = (KW > RW) ? KW : RW;
   localparam int DVW   = (DVW0 > CLW) ? DVW0 : CLW;
   localparam int EW    = CW + RIW + CIW;
   localparam int PW    = RIW + CLW;
   localparam int EPW   = gps_pkg::EPOCH_W;

   // configuration and latched dimensions
   logic [gps_pkg::CFG_W-1:0]  grid_rows_ff, grid_cols_ff;
   logic [RW-1:0]              live_rows_ff, live_rows_in;
   logic [CLW-1:0]             live_cols_ff, live_cols_in;

   // request latch
   logic                       op_ff;
   logic [gps_pkg::RAND_W-1:0] ra_ff, rb_ff;

   // working registers
   logic [KW-1:0]              count_ff;
   logic [EAW-1:0]             pick_ff;
   logic [RIW-1:0]             cur_r_ff;
   logic [CIW-1:0]             cur_c_ff;
   logic [CW-1:0]              cell_ff;
   logic [CW-1:0]              src_ff;
   logic                       nb_ok_ff, nb_ok_in;
   logic [RIW-1:0]             nb_r_ff, nb_r_in;
   logic [CIW-1:0]             nb_c_ff, nb_c_in;
   logic [CW-1:0]              ncell;
   logic [PW-1:0]              prod;

   // visited map, tagged with the tree epoch
   logic [EPW-1:0]             vis_mem [CELLS];
   logic [EPW-1:0]             vis_rd_ff;
   logic [CW-1:0]              vis_rd_addr;
   logic [EPW-1:0]             epoch_ff;
   logic                       clr_busy_ff;
   logic [CW-1:0]              clr_idx_ff;

   // edge list
   logic [EW-1:0]              edge_mem [EDGE_DEPTH];
   logic [EW-1:0]              edge_rd_ff;
   logic [EAW-1:0]             edge_rd_addr;
   logic                       push_fire;

   // divider
   logic                       div_done;
   logic [DVW-1:0]             div_rem;
   logic [gps_pkg::RAND_W-1:0] div_dividend;
   logic [DVW-1:0]             div_divisor;

   // response register
   logic                           rsp_valid_ff;
   logic [1:0]                     rsp_status_ff;
   logic [gps_pkg::CELL_OUT_W-1:0] rsp_vcell_ff, rsp_pcell_ff;
   logic [gps_pkg::LEFT_OUT_W-1:0] rsp_left_ff;

   // csr
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= gps_pkg::GRID_ROWS_RESET;
         grid_cols_ff <= gps_pkg::GRID_COLS_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            gps_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_chan.data;
            gps_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (grid_rows_ff == '0) begin
         live_rows_in = RW'(1);
      end else if (32'(grid_rows_ff) > 32'(MAX_ROWS)) begin
         live_rows_in = RW'(MAX_ROWS);
      end else begin
         live_rows_in = RW'(grid_rows_ff);
      end
      if (grid_cols_ff == '0) begin
         live_cols_in = CLW'(1);
      end else if (32'(grid_cols_ff) > 32'(MAX_COLS)) begin
         live_cols_in = CLW'(MAX_COLS);
      end else begin
         live_cols_in = CLW'(grid_cols_ff);
      end
   end

   // divider operand select
   always_comb begin
      unique case (cmd.div_sel)
         gps_pkg::DIV_ROW: begin
            div_dividend = ra_ff;
            div_divisor  = DVW'(live_rows_ff);
         end
         gps_pkg::DIV_COL: begin
            div_dividend = rb_ff;
            div_divisor  = DVW'(live_cols_ff);
         end
         default: begin
            div_dividend = ra_ff;
            div_divisor  = DVW'(count_ff);
         end
      endcase
   end

   gps_div #(.DIV_W(DVW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // neighbor candidate
   always_comb begin
      nb_r_in = cur_r_ff;
      nb_c_in = cur_c_ff;
      unique case (cmd.nb_dir)
         gps_pkg::NB_UP: begin
            nb_ok_in = (cur_r_ff != '0);
            nb_r_in  = cur_r_ff - RIW'(1);
            ncell    = cell_ff - CW'(live_cols_ff);
         end
         gps_pkg::NB_DOWN: begin
            nb_ok_in = ((RW'(cur_r_ff) + RW'(1)) < live_rows_ff);
            nb_r_in  = cur_r_ff + RIW'(1);
            ncell    = cell_ff + CW'(live_cols_ff);
         end
         gps_pkg::NB_LEFT: begin
            nb_ok_in = (cur_c_ff != '0);
            nb_c_in  = cur_c_ff - CIW'(1);
            ncell    = cell_ff - CW'(1);
         end
         default: begin
            nb_ok_in = ((CLW'(cur_c_ff) + CLW'(1)) < live_cols_ff);
            nb_c_in  = cur_c_ff + CIW'(1);
            ncell    = cell_ff + CW'(1);
         end
      endcase
   end

   assign prod = PW'(cur_r_ff) * PW'(live_cols_ff);

   assign push_fire = cmd.push_try && nb_ok_ff && (vis_rd_ff != epoch_ff)
                      && (count_ff < KW'(EDGE_DEPTH));

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.st_init) begin
         count_ff <= '0;
      end else if (cmd.edge_write_pick) begin
         count_ff <= count_ff - KW'(1);
      end else if (push_fire) begin
         count_ff <= count_ff + KW'(1);
      end
      if (cmd.load_in) begin
         op_ff <= req_chan.op;
         ra_ff <= req_chan.rand_first;
         rb_ff <= req_chan.rand_second;
      end
      if (cmd.st_init) begin
         live_rows_ff <= live_rows_in;
         live_cols_ff <= live_cols_in;
      end
      if (cmd.take_row) begin
         cur_r_ff <= RIW'(div_rem);
      end
      if (cmd.take_col) begin
         cur_c_ff <= CIW'(div_rem);
      end
      if (cmd.pick_load) begin
         pick_ff <= EAW'(div_rem);
      end
      if (cmd.edge_capture) begin
         src_ff   <= edge_rd_ff[EW-1 -: CW];
         cur_r_ff <= edge_rd_ff[RIW+CIW-1 -: RIW];
         cur_c_ff <= edge_rd_ff[CIW-1:0];
      end
      if (cmd.calc_cell) begin
         cell_ff <= CW'(prod) + CW'(cur_c_ff);
      end
      if (cmd.nb_load) begin
         nb_ok_ff <= nb_ok_in;
         nb_r_ff  <= nb_r_in;
         nb_c_ff  <= nb_c_in;
      end
   end

   // epoch and clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff    <= EPW'(1);
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + CW'(1);
         if (clr_idx_ff == CW'(CELLS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end else if (cmd.st_init) begin
         if (epoch_ff == '1) begin
            epoch_ff    <= EPW'(1);
            clr_busy_ff <= 1'b1;
            clr_idx_ff  <= '0;
         end else begin
            epoch_ff <= epoch_ff + EPW'(1);
         end
      end
   end

   // visited map
   assign vis_rd_addr = (cmd.vis_rd_sel == gps_pkg::VRD_NB) ? ncell : cell_ff;

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         vis_mem[clr_idx_ff] <= '0;
      end else if (cmd.mark) begin
         vis_mem[cell_ff] <= epoch_ff;
      end
      vis_rd_ff <= vis_mem[vis_rd_addr];
   end

   // edge list
   assign edge_rd_addr = (cmd.edge_rd_sel == gps_pkg::ERD_PICK) ? pick_ff
                         : EAW'(count_ff - KW'(1));

   always_ff @(posedge clock) begin
      if (cmd.edge_write_pick) begin
         edge_mem[pick_ff] <= edge_rd_ff;
      end else if (push_fire) begin
         edge_mem[EAW'(count_ff)] <= {cell_ff, nb_r_ff, nb_c_ff};
      end
      edge_rd_ff <= edge_mem[edge_rd_addr];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_left_ff   <= gps_pkg::LEFT_OUT_W'(count_ff);
         if (cmd.rsp_status == gps_pkg::RSP_FINISHED) begin
            rsp_vcell_ff <= '0;
         end else begin
            rsp_vcell_ff <= gps_pkg::CELL_OUT_W'(cell_ff);
         end
         if (cmd.rsp_status == gps_pkg::RSP_FINISHED
             || cmd.rsp_status == gps_pkg::RSP_STARTED) begin
            rsp_pcell_ff <= '0;
         end else begin
            rsp_pcell_ff <= gps_pkg::CELL_OUT_W'(src_ff);
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.visited_cell = rsp_vcell_ff;
   assign rsp_chan.parent_cell  = rsp_pcell_ff;
   assign rsp_chan.edges_left   = rsp_left_ff;

   assign req_chan.ready = cmd.req_ready;

   assign stat.req_valid  = req_chan.valid;
   assign stat.req_op     = req_chan.op;
   assign stat.op         = op_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.clr_busy   = clr_busy_ff;
   assign stat.div_done   = div_done;
   assign stat.vis_seen   = (vis_rd_ff == epoch_ff);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_chan.ready;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= KW'(EDGE_DEPTH))
      else $error("edge count beyond depth");
   a_pick_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.pick_load |-> (div_rem < DVW'(count_ff)))
      else $error("edge pick not below edge count");
   a_clr_epoch: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (epoch_ff == EPW'(1)))
      else $error("clearing pass with stale epoch");
   a_mark_clr: assert property (@(posedge clock) disable iff (reset)
      cmd.mark |-> !clr_busy_ff)
      else $error("cell marked during clearing pass");
`endif

endmodule

// ===== rtl/core/gps_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_ctrl
// Controller: sequences start and draw items over the datapath.
// ----------------------------------------------------------------------------
module gps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  gps_pkg::stat_type stat,
   output gps_pkg::cmd_type  cmd
);
   gps_pkg::state_type       state_ff, state_in;
   gps_pkg::rsp_status_type  code_ff, code_in;
   gps_pkg::nb_dir_type      nb_ff, nb_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gps_pkg::S_IDLE;
         code_ff  <= gps_pkg::RSP_FINISHED;
         nb_ff    <= gps_pkg::NB_UP;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         nb_ff    <= nb_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      nb_in          = nb_ff;
      cmd            = '0;
      cmd.nb_dir     = nb_ff;
      cmd.rsp_status = code_ff;
      unique case (state_ff)
         gps_pkg::S_IDLE: begin
            cmd.req_ready = !stat.clr_busy;
            if (stat.req_valid && !stat.clr_busy) begin
               cmd.load_in = 1'b1;
               if (!stat.req_op) begin
                  state_in = gps_pkg::S_ST_INIT;
               end else if (stat.count_zero) begin
                  code_in  = gps_pkg::RSP_FINISHED;
                  state_in = gps_pkg::S_RESP;
               end else begin
                  state_in = gps_pkg::S_DR_START;
               end
            end
         end
         gps_pkg::S_ST_INIT: begin
            cmd.st_init = 1'b1;
            code_in     = gps_pkg::RSP_STARTED;
            state_in    = gps_pkg::S_ST_WAITCLR;
         end
         gps_pkg::S_ST_WAITCLR: begin
            cmd.div_sel = gps_pkg::DIV_ROW;
            if (!stat.clr_busy) begin
               cmd.div_start = 1'b1;
               state_in      = gps_pkg::S_ST_DIVR;
            end
         end
         gps_pkg::S_ST_DIVR: begin
            cmd.div_sel = gps_pkg::DIV_COL;
            if (stat.div_done) begin
               cmd.take_row  = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = gps_pkg::S_ST_DIVC;
            end
         end
         gps_pkg::S_ST_DIVC: begin
            if (stat.div_done) begin
               cmd.take_col = 1'b1;
               state_in     = gps_pkg::S_MUL;
            end
         end
         gps_pkg::S_DR_START: begin
            cmd.div_sel   = gps_pkg::DIV_PICK;
            cmd.div_start = 1'b1;
            state_in      = gps_pkg::S_DR_DIVW;
         end
         gps_pkg::S_DR_DIVW: begin
            if (stat.div_done) begin
               cmd.pick_load = 1'b1;
               state_in      = gps_pkg::S_DR_RD0;
            end
         end
         gps_pkg::S_DR_RD0: begin
            cmd.edge_rd_sel = gps_pkg::ERD_PICK;
            state_in        = gps_pkg::S_DR_RD1;
         end
         gps_pkg::S_DR_RD1: begin
            cmd.edge_capture = 1'b1;
            cmd.edge_rd_sel  = gps_pkg::ERD_LAST;
            state_in         = gps_pkg::S_DR_WR;
         end
         gps_pkg::S_DR_WR: begin
            cmd.edge_write_pick = 1'b1;
            state_in            = gps_pkg::S_MUL;
         end
         gps_pkg::S_MUL: begin
            cmd.calc_cell = 1'b1;
            state_in      = stat.op ? gps_pkg::S_DR_VIS : gps_pkg::S_MARK;
         end
         gps_pkg::S_DR_VIS: begin
            cmd.vis_rd_sel = gps_pkg::VRD_CELL;
            state_in       = gps_pkg::S_DR_CHK;
         end
         gps_pkg::S_DR_CHK: begin
            if (stat.vis_seen) begin
               code_in  = gps_pkg::RSP_SKIPPED;
               state_in = gps_pkg::S_RESP;
            end else begin
               code_in  = gps_pkg::RSP_CARVED;
               state_in = gps_pkg::S_MARK;
            end
         end
         gps_pkg::S_MARK: begin
            cmd.mark = 1'b1;
            nb_in    = gps_pkg::NB_UP;
            state_in = gps_pkg::S_NB_ADDR;
         end
         gps_pkg::S_NB_ADDR: begin
            cmd.nb_load    = 1'b1;
            cmd.vis_rd_sel = gps_pkg::VRD_NB;
            state_in       = gps_pkg::S_NB_CHK;
         end
         gps_pkg::S_NB_CHK: begin
            cmd.push_try = 1'b1;
            unique case (nb_ff)
               gps_pkg::NB_UP:   nb_in = gps_pkg::NB_DOWN;
               gps_pkg::NB_DOWN: nb_in = gps_pkg::NB_LEFT;
               gps_pkg::NB_LEFT: nb_in = gps_pkg::NB_RIGHT;
               default:          nb_in = gps_pkg::NB_UP;
            endcase
            state_in = (nb_ff == gps_pkg::NB_RIGHT) ? gps_pkg::S_RESP
                                                    : gps_pkg::S_NB_ADDR;
         end
         gps_pkg::S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = gps_pkg::S_IDLE;
            end
         end
         default: state_in = gps_pkg::S_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/grid_random_prim_spanning_tree.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_random_prim_spanning_tree
// Randomized Prim spanning tree over a grid; emits a status per item with the
// visited and parent cells of each carved pair.
//  channel   | dir | payload                                        | role
//  req_chan  | in  | op, rand_first, rand_second                    | start/draw
//  rsp_chan  | out | status, visited_cell, parent_cell, edges_left  | one result
//  csr_chan  | in  | index, data                                    | grid size
//
// Start: two 31-step remainder passes (row, then column), cell multiply,
// mark and four neighbor checks. Draw: the 31-step remainder of the pick
// word dominates; then edge read and swap, multiply and visited check, plus
// mark and neighbor checks when carved; an empty list goes straight to the
// response. Epoch tagged visited map; a clearing pass of all MAX_ROWS*MAX_COLS
// cells runs after reset and on every 255th start, with req_chan.ready low.
// One item at a time; a waiting response stalls only the next response.
// ----------------------------------------------------------------------------
module grid_random_prim_spanning_tree #(
   parameter int MAX_ROWS   = gps_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = gps_pkg::DEF_MAX_COLS,
   parameter int EDGE_DEPTH = gps_pkg::DEF_EDGE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   gps_req_if.sink   req_chan,
   gps_rsp_if.source rsp_chan,
   gps_csr_if.sink   csr_chan
);
   gps_pkg::cmd_type  cmd;
   gps_pkg::stat_type stat;

   gps_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   gps_dp #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .EDGE_DEPTH (EDGE_DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule
